### src/unsorted_array_priority_queue_macros.svh
// Assertion macros for the unsorted array priority queue.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define UAPQ_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define UAPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UAPQ_ASSERT(lbl, clk, rst_n, ante, cons)
`define UAPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/uapq_pkg.sv
// Shared types and constants for the unsorted array priority queue.
// No dependencies.
`default_nettype none
package uapq_pkg;
    localparam int CAPACITY = 128;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_INS  = 3'd0,
        OP_REM  = 3'd1,
        OP_EXT  = 3'd2,
        OP_INC  = 3'd3,
        OP_RD   = 3'd4,
        OP_SORT = 3'd5,
        OP_NOP  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] key;
        logic signed [31:0] new_key;
        logic [6:0]         index;
    } req_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCAN,
        B_LAST_RD,
        B_LAST_WR,
        B_READ_WAIT,
        B_SORT_XRD,
        B_SORT_XLD,
        B_SORT_CMP,
        B_SORT_PUT
    } bstate_t;
endpackage
`default_nettype wire

### src/uapq_front.sv
// Front end: takes requests, decodes mode into an operation, and holds them
// in a two-entry queue for the back end. Depends on uapq_pkg.
`default_nettype none
module uapq_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         mode,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] new_key,
    input  wire logic [6:0]         index,
    input  wire logic               pop,
    output logic                    empty,
    output uapq_pkg::req_t          head
);
    uapq_pkg::req_t slot_reg [2];
    logic [1:0] fill_reg, fill_next;
    logic       wp_reg, rp_reg;
    logic       push;
    uapq_pkg::op_t  op_dec;
    uapq_pkg::req_t req_in;

    always_comb
    begin
        case (mode)
            3'd0:    op_dec = uapq_pkg::OP_INS;
            3'd1:    op_dec = uapq_pkg::OP_REM;
            3'd2:    op_dec = uapq_pkg::OP_EXT;
            3'd3:    op_dec = uapq_pkg::OP_INC;
            3'd4:    op_dec = uapq_pkg::OP_RD;
            3'd5:    op_dec = uapq_pkg::OP_SORT;
            default: op_dec = uapq_pkg::OP_NOP;
        endcase
    end

    assign req_in = '{op: op_dec, key: key, new_key: new_key, index: index};
    assign busy   = (fill_reg == 2'd2);
    assign empty  = (fill_reg == 2'd0);
    assign push   = start && !busy;
    assign head   = slot_reg[rp_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= req_in;
    end
endmodule
`default_nettype wire

### src/uapq_back.sv
// Back end: key store, count and the sequencer that scans, removes and sorts.
// Depends on uapq_pkg and unsorted_array_priority_queue_macros.svh.
`default_nettype none
`include "unsorted_array_priority_queue_macros.svh"
module uapq_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  empty,
    input  wire uapq_pkg::req_t        head,
    output logic                       pop,
    output logic                       done,
    output logic signed [31:0]         result_value,
    output logic [7:0]                 element_count,
    output logic [2:0]                 status
);
    localparam int AW    = uapq_pkg::AW;
    localparam int CNT_W = uapq_pkg::CNT_W;

    logic signed [31:0] mem [uapq_pkg::CAPACITY];
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr, wa;
    logic signed [31:0] wd;
    logic               mem_we;

    uapq_pkg::bstate_t  state_reg, state_next;
    uapq_pkg::req_t     req_reg, req_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, ptr_reg, ptr_next;
    logic [CNT_W-1:0]   i_reg, i_next, j_reg, j_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next, pos_reg, pos_next;
    logic signed [31:0] best_reg, best_next, x_reg, x_next;
    logic               res_vld_reg, res_vld_next;
    logic signed [31:0] res_val_reg, res_val_next;
    logic [7:0]         res_cnt_reg, res_cnt_next;
    uapq_pkg::status_t  res_st_reg, res_st_next;

    logic [CNT_W-1:0] cnt_last, i_inc, jm1, jm2;
    logic hit, at_last, better, x_ge, j_one, i_end, rd_ok, full;

    assign cnt_last = cnt_reg - CNT_W'(1);
    assign i_inc    = i_reg + CNT_W'(1);
    assign jm1      = j_reg - CNT_W'(1);
    assign jm2      = j_reg - CNT_W'(2);
    assign hit      = cmp_vld_reg && (rd_data_reg == req_reg.key);
    assign at_last  = cmp_vld_reg && (cmp_idx_reg == cnt_last[AW-1:0]);
    assign better   = (cmp_idx_reg == '0) || (rd_data_reg > best_reg);
    assign x_ge     = (x_reg >= rd_data_reg);
    assign j_one    = (j_reg == CNT_W'(1));
    assign i_end    = (i_inc >= cnt_reg);
    assign rd_ok    = (32'(head.index) < 32'(cnt_reg));
    assign full     = (cnt_reg == CNT_W'(uapq_pkg::CAPACITY));
    assign pop      = (state_reg == uapq_pkg::B_IDLE) && !empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uapq_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    case (head.op)
                        uapq_pkg::OP_REM, uapq_pkg::OP_INC, uapq_pkg::OP_EXT:
                            if (cnt_reg != '0)
                                state_next = uapq_pkg::B_SCAN;
                        uapq_pkg::OP_RD:
                            if (rd_ok)
                                state_next = uapq_pkg::B_READ_WAIT;
                        uapq_pkg::OP_SORT:
                            if (cnt_reg > CNT_W'(1))
                                state_next = uapq_pkg::B_SORT_XRD;
                        default: state_next = uapq_pkg::B_IDLE;
                    endcase
                end
            end
            uapq_pkg::B_SCAN:
            begin
                if (req_reg.op == uapq_pkg::OP_EXT)
                begin
                    if (at_last)
                        state_next = uapq_pkg::B_LAST_RD;
                end
                else if (hit)
                    state_next = (req_reg.op == uapq_pkg::OP_INC) ? uapq_pkg::B_IDLE
                                                                   : uapq_pkg::B_LAST_RD;
                else if (at_last)
                    state_next = uapq_pkg::B_IDLE;
            end
            uapq_pkg::B_LAST_RD:   state_next = uapq_pkg::B_LAST_WR;
            uapq_pkg::B_LAST_WR:   state_next = uapq_pkg::B_IDLE;
            uapq_pkg::B_READ_WAIT: state_next = uapq_pkg::B_IDLE;
            uapq_pkg::B_SORT_XRD:  state_next = uapq_pkg::B_SORT_XLD;
            uapq_pkg::B_SORT_XLD:  state_next = uapq_pkg::B_SORT_CMP;
            uapq_pkg::B_SORT_CMP:
            begin
                if (x_ge)
                    state_next = j_one ? uapq_pkg::B_SORT_PUT : uapq_pkg::B_SORT_CMP;
                else
                    state_next = i_end ? uapq_pkg::B_IDLE : uapq_pkg::B_SORT_XRD;
            end
            uapq_pkg::B_SORT_PUT:
                state_next = i_end ? uapq_pkg::B_IDLE : uapq_pkg::B_SORT_XRD;
            default: state_next = uapq_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        pos_next     = pos_reg;
        best_next    = best_reg;
        x_next       = x_reg;
        res_vld_next = 1'b0;
        res_val_next = '0;
        res_st_next  = uapq_pkg::ST_OK;
        mem_we       = 1'b0;
        wa           = pos_reg;
        wd           = rd_data_reg;
        rd_addr      = ptr_reg[AW-1:0];
        case (state_reg)
            uapq_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    req_next = head;
                    ptr_next = '0;
                    i_next   = CNT_W'(1);
                    case (head.op)
                        uapq_pkg::OP_INS:
                        begin
                            res_vld_next = 1'b1;
                            if (full)
                                res_st_next = uapq_pkg::ST_FULL;
                            else
                            begin
                                mem_we   = 1'b1;
                                wa       = cnt_reg[AW-1:0];
                                wd       = head.key;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        uapq_pkg::OP_REM, uapq_pkg::OP_INC:
                            if (cnt_reg == '0)
                            begin
                                res_vld_next = 1'b1;
                                res_st_next  = uapq_pkg::ST_NOT_FOUND;
                            end
                        uapq_pkg::OP_EXT:
                            if (cnt_reg == '0)
                            begin
                                res_vld_next = 1'b1;
                                res_st_next  = uapq_pkg::ST_EMPTY;
                            end
                        uapq_pkg::OP_RD:
                            if (rd_ok)
                                rd_addr = AW'(head.index);
                            else
                            begin
                                res_vld_next = 1'b1;
                                res_st_next  = uapq_pkg::ST_RANGE;
                            end
                        uapq_pkg::OP_SORT:
                            if (cnt_reg <= CNT_W'(1))
                                res_vld_next = 1'b1;
                        default: res_vld_next = 1'b1;
                    endcase
                end
            end
            uapq_pkg::B_SCAN:
            begin
                // one read issued per cycle, compared the cycle after
                if (ptr_reg < cnt_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + CNT_W'(1);
                end
                if (req_reg.op == uapq_pkg::OP_EXT)
                begin
                    if (cmp_vld_reg && better)
                    begin
                        best_next = rd_data_reg;
                        pos_next  = cmp_idx_reg;
                    end
                end
                else if (hit)
                begin
                    pos_next = cmp_idx_reg;
                    if (req_reg.op == uapq_pkg::OP_INC)
                    begin
                        mem_we       = 1'b1;
                        wa           = cmp_idx_reg;
                        wd           = req_reg.new_key;
                        res_vld_next = 1'b1;
                    end
                end
                else if (at_last)
                begin
                    res_vld_next = 1'b1;
                    res_st_next  = uapq_pkg::ST_NOT_FOUND;
                end
            end
            uapq_pkg::B_LAST_RD:
                rd_addr = cnt_last[AW-1:0];
            uapq_pkg::B_LAST_WR:
            begin
                // hole at pos is filled with the last entry
                mem_we       = 1'b1;
                wa           = pos_reg;
                wd           = rd_data_reg;
                cnt_next     = cnt_last;
                res_vld_next = 1'b1;
                if (req_reg.op == uapq_pkg::OP_EXT)
                    res_val_next = best_reg;
            end
            uapq_pkg::B_READ_WAIT:
            begin
                res_vld_next = 1'b1;
                res_val_next = rd_data_reg;
            end
            uapq_pkg::B_SORT_XRD:
            begin
                rd_addr = i_reg[AW-1:0];
                j_next  = i_reg;
            end
            uapq_pkg::B_SORT_XLD:
            begin
                x_next  = rd_data_reg;
                rd_addr = jm1[AW-1:0];
            end
            uapq_pkg::B_SORT_CMP:
            begin
                mem_we = 1'b1;
                wa     = j_reg[AW-1:0];
                if (x_ge)
                begin
                    wd      = rd_data_reg;
                    j_next  = jm1;
                    rd_addr = jm2[AW-1:0];
                end
                else
                begin
                    wd     = x_reg;
                    i_next = i_inc;
                    if (i_end)
                        res_vld_next = 1'b1;
                end
            end
            uapq_pkg::B_SORT_PUT:
            begin
                mem_we = 1'b1;
                wa     = j_reg[AW-1:0];
                wd     = x_reg;
                i_next = i_inc;
                if (i_end)
                    res_vld_next = 1'b1;
            end
            default: res_vld_next = 1'b0;
        endcase
        res_cnt_next = 8'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= uapq_pkg::B_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        ptr_reg     <= ptr_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        cmp_idx_reg <= cmp_idx_next;
        pos_reg     <= pos_next;
        best_reg    <= best_next;
        x_reg       <= x_next;
        res_val_reg <= res_val_next;
        res_cnt_reg <= res_cnt_next;
        res_st_reg  <= res_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wa] <= wd;
        rd_data_reg <= mem[rd_addr];
    end

    assign done          = res_vld_reg;
    assign result_value  = res_val_reg;
    assign element_count = res_cnt_reg;
    assign status        = res_st_reg;

    `UAPQ_ASSERT(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(uapq_pkg::CAPACITY))
    `UAPQ_ASSERT_NEXT(a_cnt_step, clk, rst_n, 1'b1, (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CNT_W'(1)) || (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
    `UAPQ_ASSERT(a_scan_we, clk, rst_n, mem_we && (state_reg == uapq_pkg::B_SCAN), req_reg.op == uapq_pkg::OP_INC)
endmodule
`default_nettype wire

### src/unsorted_array_priority_queue.sv
// Top level of the unsorted array priority queue.
// Depends on uapq_pkg, uapq_front and uapq_back.
//
// A request (mode, key, new_key, index) is taken at a rising edge with start
// high and busy low. A two-entry request queue sits in front of the engine,
// so busy rises only when two requests wait behind the one at work.
// Each request gives one result on result_value, element_count and status,
// marked by done for exactly one cycle; the receiver cannot stall.
// Work after the request reaches the engine:
//   insert, unused modes, errors found up front: no scan
//   read at index: a single read of the key store
//   remove, increase: scan until the key is found; extract max: full scan
//     (scan of the key store, one entry per cycle through its single read port)
//   remove and extract max then move the last entry into the freed slot
//   sort: insertion sort
// Reset empties the queue (count zero); stored keys are not cleared.
`default_nettype none
module unsorted_array_priority_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         mode,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] new_key,
    input  wire logic [6:0]         index,
    output logic                    done,
    output logic signed [31:0]      result_value,
    output logic [7:0]              element_count,
    output logic [2:0]              status
);
    uapq_pkg::req_t head;
    logic           empty, pop;

    uapq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .mode    (mode),
        .key     (key),
        .new_key (new_key),
        .index   (index),
        .pop     (pop),
        .empty   (empty),
        .head    (head)
    );

    uapq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .head          (head),
        .pop           (pop),
        .done          (done),
        .result_value  (result_value),
        .element_count (element_count),
        .status        (status)
    );
endmodule
`default_nettype wire

### tb/tb_unsorted_array_priority_queue.sv
// Testbench for the unsorted array priority queue: directed and random requests,
// checked against an in-bench model of the key store. Depends on uapq_pkg and unsorted_array_priority_queue.
`default_nettype none
module tb_unsorted_array_priority_queue;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] key;
        logic signed [31:0] new_key;
        logic [6:0]         index;
    } pq_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         count;
        logic [2:0]         status;
    } pq_rsp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         mode = '0;
    logic signed [31:0] key = '0;
    logic signed [31:0] new_key = '0;
    logic [6:0]         index = '0;
    logic               done;
    logic signed [31:0] result_value;
    logic [7:0]         element_count;
    logic [2:0]         status;

    unsorted_array_priority_queue uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .key(key), .new_key(new_key), .index(index),
        .done(done), .result_value(result_value),
        .element_count(element_count), .status(status)
    );

    always #5 clk = ~clk;

    pq_req_t pending_reqs[$];
    pq_rsp_t expected_rsps[$];
    logic signed [31:0] model_keys[uapq_pkg::CAPACITY];
    int model_count = 0;
    int mismatches = 0;
    int gap_left = 0;

    // keys issued so far, so remove/increase usually hit
    logic signed [31:0] key_pool[$];

    function automatic pq_rsp_t queue_apply(pq_req_t r);
        pq_rsp_t o;
        int pos;
        int i;
        int j;
        logic signed [31:0] x;
        o = '0;
        o.status = uapq_pkg::ST_OK;
        pos = -1;
        case (r.mode)
            uapq_pkg::OP_INS: begin
                if (model_count >= uapq_pkg::CAPACITY) o.status = uapq_pkg::ST_FULL;
                else begin
                    model_keys[model_count] = r.key;
                    model_count++;
                end
            end
            uapq_pkg::OP_REM, uapq_pkg::OP_INC: begin
                for (i = 0; i < model_count && pos < 0; i++)
                    if (model_keys[i] == r.key) pos = i;
                if (pos < 0) o.status = uapq_pkg::ST_NOT_FOUND;
                else if (r.mode == uapq_pkg::OP_INC) model_keys[pos] = r.new_key;
                else begin
                    model_keys[pos] = model_keys[model_count-1];
                    model_count--;
                end
            end
            uapq_pkg::OP_EXT: begin
                if (model_count == 0) o.status = uapq_pkg::ST_EMPTY;
                else begin
                    pos = 0;
                    for (i = 1; i < model_count; i++)
                        if (model_keys[i] > model_keys[pos]) pos = i;
                    o.value = model_keys[pos];
                    model_keys[pos] = model_keys[model_count-1];
                    model_count--;
                end
            end
            uapq_pkg::OP_RD: begin
                if (r.index < model_count) o.value = model_keys[r.index];
                else o.status = uapq_pkg::ST_RANGE;
            end
            uapq_pkg::OP_SORT: begin
                for (i = 1; i < model_count; i++) begin
                    x = model_keys[i];
                    j = i;
                    while (j > 0 && x >= model_keys[j-1]) begin
                        model_keys[j] = model_keys[j-1];
                        j--;
                    end
                    model_keys[j] = x;
                end
            end
            default: ;
        endcase
        o.count = model_count[7:0];
        return o;
    endfunction

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic push_req(input logic [2:0] m, input logic signed [31:0] k,
                            input logic signed [31:0] nk, input logic [6:0] ix);
        pq_req_t r;
        r.mode = m; r.key = k; r.new_key = nk; r.index = ix;
        pending_reqs.push_back(r);
        if (m == uapq_pkg::OP_INS || m == uapq_pkg::OP_INC)
            key_pool.push_back(m == uapq_pkg::OP_INS ? k : nk);
    endtask

    // driver: request held until start && !busy is seen at an edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_rsps.push_back(queue_apply({mode, key, new_key, index}));
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    pq_req_t r;
                    r = pending_reqs.pop_front();
                    mode <= r.mode; key <= r.key; new_key <= r.new_key; index <= r.index;
                    start <= 1'b1;
                    // no idling over the last part of the run
                    if (pending_reqs.size() > 200 && $urandom_range(0, 7) == 0)
                        gap_left <= $urandom_range(1, 19);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result value=%0d", result_value);
            end else begin
                pq_rsp_t e;
                e = expected_rsps.pop_front();
                if (e.value !== result_value || e.count !== element_count
                    || e.status !== status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp v=%0d c=%0d s=%0d got v=%0d c=%0d s=%0d",
                                 e.value, e.count, e.status,
                                 result_value, element_count, status);
                end
            end
        end
    end

    initial begin
        int n;
        int i;
        int m;
        logic signed [31:0] k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed: empty-queue cases, extremes, full, unused modes
        push_req(uapq_pkg::OP_EXT, 0, 0, 0);
        push_req(uapq_pkg::OP_REM, 5, 0, 0);
        push_req(uapq_pkg::OP_INC, 5, 6, 0);
        push_req(uapq_pkg::OP_RD, 0, 0, 7'd127);
        push_req(uapq_pkg::OP_SORT, 0, 0, 0);
        push_req(3'd6, -1, -1, 7'h7f);
        push_req(3'd7, -1, -1, 7'h7f);
        push_req(uapq_pkg::OP_INS, 32'sh7fffffff, 0, 0);
        push_req(uapq_pkg::OP_INS, 32'sh80000000, 0, 0);
        push_req(uapq_pkg::OP_INS, -1, 0, 0);
        push_req(uapq_pkg::OP_INS, 32'sh7fffffff, 0, 0);
        push_req(uapq_pkg::OP_INC, -1, 32'sh80000000, 0);
        push_req(uapq_pkg::OP_INC, 32'sh7fffffff, -7, 0);
        push_req(uapq_pkg::OP_RD, 0, 0, 7'd0);
        push_req(uapq_pkg::OP_RD, 0, 0, 7'd4);
        push_req(uapq_pkg::OP_SORT, 0, 0, 0);
        push_req(uapq_pkg::OP_RD, 0, 0, 7'd3);
        push_req(uapq_pkg::OP_EXT, 0, 0, 0);
        push_req(uapq_pkg::OP_REM, 32'sh80000000, 0, 0);
        push_req(uapq_pkg::OP_REM, 12345, 0, 0);
        for (i = 0; i < uapq_pkg::CAPACITY + 2; i++)
            push_req(uapq_pkg::OP_INS, pick_key(), 0, 0);
        push_req(uapq_pkg::OP_RD, 0, 0, 7'd127);
        push_req(uapq_pkg::OP_EXT, 0, 0, 0);
        n = 0;
        while (n < 1250) begin
            m = $urandom_range(0, 99);
            k = (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
                ? key_pool[$urandom_range(0, key_pool.size() - 1)] : pick_key();
            if (m < 30)
                push_req(uapq_pkg::OP_INS, pick_key(), $signed($urandom()), 7'($urandom()));
            else if (m < 45)
                push_req(uapq_pkg::OP_REM, k, $signed($urandom()), 7'($urandom()));
            else if (m < 60)
                push_req(uapq_pkg::OP_EXT, $signed($urandom()), 0, 0);
            else if (m < 72)
                push_req(uapq_pkg::OP_INC, k, pick_key(), 7'($urandom()));
            else if (m < 92)
                push_req(uapq_pkg::OP_RD, $signed($urandom()), 0,
                         7'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom()));
            else if (m < 95)
                push_req(uapq_pkg::OP_SORT, $signed($urandom()), 0, 7'($urandom()));
            else push_req(3'($urandom_range(6, 7)), $signed($urandom()),
                          $signed($urandom()), 7'($urandom()));
            n++;
        end
        push_req(uapq_pkg::OP_SORT, 0, 0, 0);
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_rsps.size() == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("** unsorted_array_priority_queue: PASSED **");
        else
            $display("** unsorted_array_priority_queue: FAILED **");
        $finish;
    end

    initial begin
        #1000000000;
        $display("** unsorted_array_priority_queue: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
